>>> design/ilt_pkg.sv
// ilt_pkg: command and status codes, fixed field widths and the cell control
// struct for the indexed list table. No dependencies.
package ilt_pkg;

  localparam int CMD_W  = 4;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int OCNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_APPEND = 4'd0;
  localparam logic [CMD_W-1:0] CMD_DROP   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 4'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 4'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_READ   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_FIRST  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_LAST   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_FIND   = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // Broadcast enables for the cell row.
  typedef struct packed {
    logic ins;  // shift up from sel index, load new word there
    logic rem;  // shift down from sel index
    logic rot;  // rotate live entries toward cell 0, wrap at wrap index
  } cell_ctl_t;

endpackage

>>> design/ilt_in_if.sv
// ilt_in_if: command channel of the indexed list table (valid/ready + word).
// Depends on ilt_pkg for field widths.
interface ilt_in_if import ilt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] item_value;

  modport source (output valid, output cmd, output position, output item_value,
                  input ready);
  modport sink   (input valid, input cmd, input position, input item_value,
                  output ready);
endinterface

>>> design/ilt_out_if.sv
// ilt_out_if: result channel of the indexed list table (valid/ready + word).
// Depends on ilt_pkg for field widths.
interface ilt_out_if import ilt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  read_word;
  logic [OCNT_W-1:0] match_index;
  logic              match_found;
  logic [OCNT_W-1:0] entry_count;

  modport source (output valid, output status, output read_word, output match_index,
                  output match_found, output entry_count, input ready);
  modport sink   (input valid, input status, input read_word, input match_index,
                  input match_found, input entry_count, output ready);
endinterface

>>> design/ilt_cell.sv
// ilt_cell: one entry of the list row; holds a word and loads it from its
// neighbors, the new word or the head cell. Depends on ilt_pkg.
module ilt_cell import ilt_pkg::*; #(
  parameter int IDX       = 0,
  parameter int WORD_BITS = 32,
  parameter int CMP_W     = 7
) (
  input  logic                 clk,
  input  cell_ctl_t            ctl,
  input  logic [CMP_W-1:0]     sel_idx,
  input  logic [CMP_W-1:0]     wrap_idx,
  input  logic [WORD_BITS-1:0] new_word,
  input  logic [WORD_BITS-1:0] head_word,
  input  logic [WORD_BITS-1:0] prev_word,
  input  logic [WORD_BITS-1:0] next_word,
  output logic [WORD_BITS-1:0] word_q
);

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctl.ins) begin
      if (MY_IDX > sel_idx) begin
        word_nxt = prev_word;
      end else if (MY_IDX == sel_idx) begin
        word_nxt = new_word;
      end
    end else if (ctl.rem) begin
      if (MY_IDX >= sel_idx) begin
        word_nxt = next_word;
      end
    end else if (ctl.rot) begin
      if (MY_IDX == wrap_idx) begin
        word_nxt = head_word;
      end else if (MY_IDX < wrap_idx) begin
        word_nxt = next_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;

endmodule

>>> design/indexed_list_table.sv
// Indexed list table: an ordered list of up to DEPTH words with a live count.
// Append, drop last, insert, remove, clear and read first are answered
// straight from the idle state; the cell row moves its entries in parallel.
// Read index, read last and find enter a scan state, in which the live
// entries rotate through cell 0 once (restoring order) while the head is
// compared; on an empty list they finish at once. Every command gives one
// result word; a new command is taken once the previous result is being taken.
// Depends on ilt_pkg, ilt_in_if, ilt_out_if and ilt_cell.
module indexed_list_table import ilt_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input logic       clk,
  input logic       rst_n,
  ilt_in_if.sink    in_ch,
  ilt_out_if.source out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int VW    = (WORD_BITS < VAL_W) ? WORD_BITS : VAL_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // state codes
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;             // scan step = index now at head
  logic [IDX_W-1:0] target_r, target_nxt;   // index a read scan captures
  logic [CMD_W-1:0] scan_cmd_r, scan_cmd_nxt;
  logic [WORD_BITS-1:0] key_r, key_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [VAL_W-1:0]  out_word_r, out_word_nxt;
  logic [CNT_W-1:0]  out_midx_r, out_midx_nxt;
  logic              out_found_r, out_found_nxt;

  // cell row
  cell_ctl_t ctl;
  logic [CMP_W-1:0] sel_idx;
  logic [CMP_W-1:0] wrap_idx;
  logic [DEPTH-1:0][WORD_BITS-1:0] cell_q;
  logic [DEPTH-1:0][WORD_BITS-1:0] prev_w;
  logic [DEPTH-1:0][WORD_BITS-1:0] next_w;
  logic [WORD_BITS-1:0] head_word;
  logic [WORD_BITS-1:0] in_word;

  logic accept;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] k_ext;
  logic list_empty;
  logic list_full;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  assign in_word    = WORD_BITS'(in_ch.item_value[VW-1:0]);
  assign head_word  = cell_q[0];
  assign pos_ext    = CMP_W'(in_ch.position);
  assign count_ext  = CMP_W'(count_r);
  assign k_ext      = CMP_W'(k_r);
  assign list_empty = (count_r == '0);
  assign list_full  = (count_r >= FULL_CNT);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    target_nxt     = target_r;
    scan_cmd_nxt   = scan_cmd_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_word_nxt   = out_word_r;
    out_midx_nxt   = out_midx_r;
    out_found_nxt  = out_found_r;
    ctl            = '0;
    sel_idx        = pos_ext;
    wrap_idx       = count_ext - CMP_W'(1);   // last live entry

    if (accept) begin
      out_status_nxt = ST_OK;
      out_word_nxt   = '0;
      out_midx_nxt   = '0;
      out_found_nxt  = 1'b0;
      out_valid_nxt  = 1'b1;
      case (in_ch.cmd)
        CMD_APPEND: begin
          if (list_full) begin
            out_status_nxt = ST_FULL;
          end else begin
            ctl.ins   = 1'b1;
            sel_idx   = count_ext;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_DROP: begin
          if (list_empty) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        CMD_INSERT: begin
          if (pos_ext > count_ext) begin
            out_status_nxt = ST_RANGE;
          end else if (list_full) begin
            out_status_nxt = ST_FULL;
          end else begin
            ctl.ins   = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_REMOVE: begin
          if (pos_ext >= count_ext) begin
            out_status_nxt = ST_RANGE;
          end else begin
            ctl.rem   = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        CMD_CLEAR: begin
          count_nxt = '0;
        end
        CMD_READ: begin
          if (pos_ext >= count_ext) begin
            out_status_nxt = ST_RANGE;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_SCAN;
            k_nxt         = '0;
            target_nxt    = IDX_W'(pos_ext);
            scan_cmd_nxt  = CMD_READ;
          end
        end
        CMD_FIRST: begin
          if (list_empty) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            out_word_nxt = VAL_W'(head_word[VW-1:0]);
          end
        end
        CMD_LAST: begin
          if (list_empty) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_SCAN;
            k_nxt         = '0;
            target_nxt    = IDX_W'(wrap_idx);
            scan_cmd_nxt  = CMD_LAST;
          end
        end
        CMD_FIND: begin
          // absent value reports the count; empty list answers at once
          out_midx_nxt = count_r;
          if (!list_empty) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_SCAN;
            k_nxt         = '0;
            key_nxt       = in_word;
            scan_cmd_nxt  = CMD_FIND;
          end
        end
        default: begin
        end
      endcase
    end

    if (state_r == S_SCAN) begin
      ctl.rot = 1'b1;
      if (scan_cmd_r == CMD_FIND) begin
        if (!out_found_r && (head_word == key_r)) begin
          out_found_nxt = 1'b1;
          out_midx_nxt  = CNT_W'(k_r);
        end
      end else if (k_r == target_r) begin
        out_word_nxt = VAL_W'(head_word[VW-1:0]);
      end
      if (k_ext == wrap_idx) begin
        // full turn done, order restored
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end else begin
        k_nxt = k_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    target_r     <= target_nxt;
    scan_cmd_r   <= scan_cmd_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_word_r   <= out_word_nxt;
    out_midx_r   <= out_midx_nxt;
    out_found_r  <= out_found_nxt;
  end

  // row of entry cells; ends see zero neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev_w[g] = '0;
    end else begin : g_mid_prev
      assign prev_w[g] = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_w[g] = '0;
    end else begin : g_mid_next
      assign next_w[g] = cell_q[g+1];
    end

    ilt_cell #(
      .IDX       (g),
      .WORD_BITS (WORD_BITS),
      .CMP_W     (CMP_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .sel_idx   (sel_idx),
      .wrap_idx  (wrap_idx),
      .new_word  (in_word),
      .head_word (head_word),
      .prev_word (prev_w[g]),
      .next_word (next_w[g]),
      .word_q    (cell_q[g])
    );
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.read_word   = out_word_r;
  assign out_ch.match_index = OCNT_W'(out_midx_r);
  assign out_ch.match_found = out_found_r;
  assign out_ch.entry_count = OCNT_W'(count_r);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("live count above depth");

  a_scan_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !out_valid_r)
    else $error("result pending during scan");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (k_ext < count_ext))
    else $error("scan step past live entries");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.cmd == CMD_APPEND) && !list_full)
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("append did not grow list");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.cmd == CMD_CLEAR)) |=> (count_r == '0))
    else $error("clear left entries");
`endif

endmodule

>>> tb/indexed_list_table_checker.sv
// indexed_list_table_checker: watches the command and result channels, keeps
// its own copy of the list, predicts each result word and compares it.
// Depends on ilt_pkg, ilt_in_if and ilt_out_if.
module indexed_list_table_checker import ilt_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  ilt_in_if    cmd_mon,
  ilt_out_if   res_mon,
  output int   fail_count,
  output int   pending,
  output int   model_count
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  read_word;
    logic [OCNT_W-1:0] match_index;
    logic              match_found;
    logic [OCNT_W-1:0] entry_count;
  } list_result_t;

  // Owed result words; the block holds at most one, so a few slots suffice.
  localparam int EXP_SLOTS = 4;

  logic [VAL_W-1:0] list_words [DEPTH];
  int               list_len;
  list_result_t     exp_ring [EXP_SLOTS];
  int               exp_rd;
  int               exp_wr;
  int               exp_cnt;

  // Applies one command to the list copy and returns the result word it gives.
  function automatic list_result_t apply_command(input logic [CMD_W-1:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [VAL_W-1:0] val);
    list_result_t r;
    int p;
    r = '0;
    p = int'(pos);
    case (op)
      CMD_APPEND: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_words[list_len] = val;
          list_len++;
        end
      end
      CMD_DROP: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else list_len--;
      end
      CMD_INSERT: begin
        if (p > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = list_len; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = val;
          list_len++;
        end
      end
      CMD_REMOVE: begin
        if (p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      CMD_CLEAR: list_len = 0;
      CMD_READ: begin
        if (p >= list_len) r.status = ST_RANGE;
        else r.read_word = list_words[p];
      end
      CMD_FIRST: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else r.read_word = list_words[0];
      end
      CMD_LAST: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else r.read_word = list_words[list_len-1];
      end
      CMD_FIND: begin
        r.match_index = OCNT_W'(list_len);
        for (int i = 0; i < list_len && !r.match_found; i++) begin
          if (list_words[i] == val) begin
            r.match_index = OCNT_W'(i);
            r.match_found = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = OCNT_W'(list_len);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      list_len = 0;
      exp_rd   = 0;
      exp_wr   = 0;
      exp_cnt  = 0;
    end else begin
      // Result side first: a word leaving now belongs to an older command.
      if (res_mon.valid && res_mon.ready) begin
        got = '{res_mon.status, res_mon.read_word, res_mon.match_index,
                res_mon.match_found, res_mon.entry_count};
        if (exp_cnt == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected word: st=%0d rd=%h idx=%0d fnd=%0d cnt=%0d",
                     $realtime, got.status, got.read_word, got.match_index,
                     got.match_found, got.entry_count);
          fail_count++;
        end else begin
          want    = exp_ring[exp_rd];
          exp_rd  = (exp_rd + 1) % EXP_SLOTS;
          exp_cnt = exp_cnt - 1;
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch exp st=%0d rd=%h idx=%0d fnd=%0d cnt=%0d",
                       $realtime, want.status, want.read_word, want.match_index,
                       want.match_found, want.entry_count);
              $display("%0t:          got st=%0d rd=%h idx=%0d fnd=%0d cnt=%0d",
                       $realtime, got.status, got.read_word, got.match_index,
                       got.match_found, got.entry_count);
            end
            fail_count++;
          end
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        want = apply_command(cmd_mon.cmd, cmd_mon.position, cmd_mon.item_value);
        if (exp_cnt == EXP_SLOTS) begin
          if (fail_count < 10)
            $display("%0t: too many result words owed", $realtime);
          fail_count++;
        end else begin
          exp_ring[exp_wr] = want;
          exp_wr           = (exp_wr + 1) % EXP_SLOTS;
          exp_cnt          = exp_cnt + 1;
        end
      end
    end
    pending     <= exp_cnt;
    model_count <= list_len;
  end

endmodule

>>> tb/indexed_list_table_test.sv
// indexed_list_table_test: top of the list table bench. Drives command words,
// pulls result words with random stalls and gives the verdict.
// Depends on ilt_pkg, ilt_in_if, ilt_out_if, indexed_list_table and the checker.
module indexed_list_table_test;
  import ilt_pkg::*;

  localparam int DEPTH       = 64;
  localparam int HOLD_CYCLES = 300;  // long receiver stall, fills the block
  localparam int TAIL_CYCLES = 80;   // idle tail after the final result wait

  logic clk = 1'b0;
  logic rst_n;

  int fail_count;
  int pending;      // result words still owed, as registered by the checker
  int model_count;  // list length after accepted commands, as registered by the checker

  int sent;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_reqs;

  ilt_in_if  in_ch ();
  ilt_out_if out_ch ();

  indexed_list_table #(.DEPTH(DEPTH), .WORD_BITS(VAL_W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  indexed_list_table_checker #(.DEPTH(DEPTH)) list_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_mon     (in_ch),
    .res_mon     (out_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .model_count (model_count)
  );

  always #10 clk = ~clk;

  // Receiver: random stalls per phase, plus a long hold-off on request.
  // The hold-off is counted here so the sender keeps offering words meanwhile.
  always @(posedge clk) begin
    static int hold_seen = 0;
    static int hold_left = 0;
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one command word and return at the edge that takes it. Valid is
  // only lowered when an idle cycle is inserted, so back-to-back words never
  // see two assignments to valid in one step.
  task automatic send_word(input logic [CMD_W-1:0] op, input int pos,
                           input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= op;
    in_ch.position   <= POS_W'(pos);
    in_ch.item_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Sender pause until every owed result word is back.
  task automatic wait_results;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Values: half from a small pool so finds hit and duplicates occur.
  function automatic logic [VAL_W-1:0] pick_value;
    if ($urandom_range(1) == 0) return $urandom();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h0000_0001;
      4: return 32'hA5A5_A5A5;
      5: return 32'h5A5A_5A5A;
      6: return 32'h0000_0042;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // Positions: mostly inside the list, often at its end, some far beyond.
  function automatic int pick_pos;
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(model_count);
    if (r < 85) return model_count;
    if (r < 95) return $urandom_range(127);
    return 0;
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd;
    int r;
    r = $urandom_range(99);
    if (r < 20) return CMD_APPEND;
    if (r < 40) return CMD_INSERT;
    if (r < 52) return CMD_REMOVE;
    if (r < 58) return CMD_DROP;
    if (r < 60) return CMD_CLEAR;
    if (r < 72) return CMD_READ;
    if (r < 77) return CMD_FIRST;
    if (r < 82) return CMD_LAST;
    return CMD_FIND;
  endfunction

  // Fill to full, probe the full list, then clear or drain by removes and drops.
  task automatic fill_and_drain;
    while (model_count < DEPTH) send_word(CMD_APPEND, 0, pick_value());
    send_word(CMD_APPEND, 0, pick_value());
    send_word(CMD_INSERT, $urandom_range(DEPTH), pick_value());
    send_word(CMD_INSERT, $urandom_range(127, DEPTH + 1), pick_value());
    send_word(CMD_READ, $urandom_range(DEPTH - 1), 0);
    send_word(CMD_LAST, 0, 0);
    send_word(CMD_FIND, 0, pick_value());
    if ($urandom_range(1) == 0) begin
      send_word(CMD_CLEAR, $urandom_range(127), $urandom());
    end else begin
      while (model_count > 0) begin
        if ($urandom_range(3) == 0) send_word(CMD_DROP, 0, 0);
        else send_word(CMD_REMOVE, $urandom_range(model_count - 1), 0);
      end
      send_word(CMD_DROP, 0, 0);
    end
  endtask

  task automatic random_mix(input int n);
    logic [CMD_W-1:0] op;
    repeat (n) begin
      op = pick_cmd();
      send_word(op, pick_pos(), pick_value());
    end
  endtask

  // Anything the fields allow: unknown commands and wild positions included.
  task automatic noise(input int n);
    repeat (n) send_word(CMD_W'($urandom_range(15)), $urandom_range(127), $urandom());
  endtask

  task automatic random_phase(input int target);
    int r;
    while (sent < target) begin
      r = $urandom_range(99);
      if (r < 12) fill_and_drain();
      else if (r < 75) random_mix($urandom_range(4, 20));
      else if (r < 88) repeat ($urandom_range(2, 8)) send_word(CMD_FIND, 0, pick_value());
      else noise($urandom_range(1, 6));
    end
  endtask

  // Directed opening: every command, empty-list and range cases, field extremes.
  task automatic directed_part;
    send_word(CMD_DROP,   0,   0);             // drop on empty
    send_word(CMD_FIRST,  0,   0);             // first on empty
    send_word(CMD_LAST,   0,   0);             // last on empty
    send_word(CMD_READ,   0,   0);             // read on empty is a range error
    send_word(CMD_REMOVE, 0,   0);             // remove on empty is a range error
    send_word(CMD_FIND,   0,   32'h0000_0000); // find on empty
    send_word(CMD_INSERT, 1,   32'h1111_1111); // past the end
    send_word(CMD_INSERT, 127, 32'h2222_2222); // all position bits set
    send_word(CMD_INSERT, 0,   32'hFFFF_FFFF);
    send_word(CMD_APPEND, 0,   32'h0000_0000);
    send_word(CMD_INSERT, 2,   32'hA5A5_A5A5); // position equal to count appends
    send_word(CMD_INSERT, 1,   32'h5A5A_5A5A); // middle insert shifts up
    send_word(CMD_READ,   1,   0);
    send_word(CMD_FIRST,  0,   0);
    send_word(CMD_LAST,   0,   0);
    send_word(CMD_FIND,   0,   32'h0000_0000); // present
    send_word(CMD_FIND,   0,   32'h1234_5678); // absent, index is count
    send_word(CMD_REMOVE, 0,   0);             // shifts down
    send_word(CMD_REMOVE, 3,   0);             // position equal to count
    send_word(CMD_READ,   64,  0);
    send_word(CMD_W'(9),  5,   32'hDEAD_BEEF); // unknown commands leave the list as is
    send_word(CMD_W'(15), 127, 32'hFFFF_FFFF);
    send_word(CMD_CLEAR,  0,   0);
    send_word(CMD_LAST,   0,   0);
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_APPEND;
    in_ch.position   <= '0;
    in_ch.item_value <= '0;
    sent          = 0;
    hold_reqs     = 0;
    send_idle_pct = 6;
    recv_idle_pct = 76;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase 1: sender rarely idles, receiver mostly stalls.
    directed_part();
    random_phase(300);
    hold_reqs++;            // receiver holds off while words keep coming
    random_phase(640);
    wait_results();

    // Phase 2: roles swapped.
    send_idle_pct = 76;
    recv_idle_pct = 6;
    random_phase(1280);
    wait_results();

    // Phase 3: full rate both sides, one more long hold-off.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(1500);
    hold_reqs++;
    random_phase(1920);

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Timeout: several times the slowest legal run.
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
design/ilt_pkg.sv
design/ilt_in_if.sv
design/ilt_out_if.sv
design/ilt_cell.sv
design/indexed_list_table.sv
tb/indexed_list_table_checker.sv
tb/indexed_list_table_test.sv
